/* rtl/etot_pkg.sv */
`default_nettype none

package etot_pkg;

    // Default width of the operand and of the result.
    localparam int VALUE_BITS_DEF = 31;

    // Sequencer states. TEST, STRIP, REDUCE and LAST run bit-serial divisions.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_STRIP,
        ST_REDUCE,
        ST_LAST,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

/* rtl/euler_totient_top.sv */
`default_nettype none
// Euler totient phi(n) by trial division, computed with a bit-serial divider.
// Input channel: i_in_valid / o_in_stall carry i_value_in. A transfer takes place at a
// rising edge with i_in_valid high and o_in_stall low. Only one item is in
// work at a time, so o_in_stall is high from the transfer until the result
// has been moved into the output register.
// Output channel: o_out_valid / i_out_stall carry o_totient. The result stays
// in the output register, unchanged, until the receiver lets it go. The block
// takes the next item while that result still waits. A finished result that
// finds the output register still occupied waits in the sequencer.
// Work: each division computes one quotient bit per cycle. An item needs
// one division per trial divisor, plus the divisions that strip a found
// factor and reduce the running product, plus entry and hand-off. A large
// prime takes the longest, as every trial divisor up to its square root
// is tried.
// Reset (synchronous, active low) drops any item in work and empties the
// output register.
module euler_totient_top #(
    parameter int VALUE_BITS = etot_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [VALUE_BITS-1:0] i_value_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [VALUE_BITS-1:0]      o_totient
);
    import etot_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);
    localparam logic [VALUE_BITS-1:0] TWO = VALUE_BITS'(2);

    t_state r_state, n_state;

    // Working values: the unfactored rest of n, the running product, the
    // trial divisor.
    logic [VALUE_BITS-1:0] r_rest, n_rest;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_d, n_d;

    // Divider: partial remainder, dividend/quotient shift register, divisor.
    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [VALUE_BITS-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic                  r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0] r_totient, n_totient;

    // One restoring division step: bring in the next dividend bit, try the
    // subtraction, and shift the quotient bit in at the bottom.
    logic [VALUE_BITS:0]   s_shift;
    logic [VALUE_BITS:0]   s_diff;
    logic                  s_ge;
    logic [VALUE_BITS-1:0] s_rem;
    logic [VALUE_BITS-1:0] s_quo;
    logic                  s_done;
    logic [VALUE_BITS-1:0] d_inc;

    always_comb begin
        s_shift = {r_rem, r_quo[VALUE_BITS-1]};
        s_diff  = s_shift - {1'b0, r_dvs};
        s_ge    = ~s_diff[VALUE_BITS];
        s_rem   = s_ge ? s_diff[VALUE_BITS-1:0] : s_shift[VALUE_BITS-1:0];
        s_quo   = {r_quo[VALUE_BITS-2:0], s_ge};
        s_done  = (r_cnt == CNT_LAST);
        d_inc   = r_d + ONE;
    end

    always_comb begin
        n_state     = r_state;
        n_rest      = r_rest;
        n_acc       = r_acc;
        n_d         = r_d;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_totient   = r_totient;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Division states advance the divider by one bit; a state that
        // starts a new division overrides these below.
        if (r_state != ST_IDLE && r_state != ST_FINISH) begin
            n_rem = s_rem;
            n_quo = s_quo;
            n_cnt = r_cnt + CNT_W'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_rest  = i_value_in;
                    n_acc   = i_value_in;
                    n_d     = TWO;
                    n_rem   = '0;
                    n_quo   = i_value_in;
                    n_dvs   = TWO;
                    n_cnt   = '0;
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                // rest / d gives both the loop test (d <= rest/d) and the
                // divisibility check.
                if (s_done) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (r_d > s_quo) begin
                        if (r_rest > ONE) begin
                            n_quo   = r_acc;
                            n_dvs   = r_rest;
                            n_state = ST_LAST;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end else if (s_rem == '0) begin
                        n_rest  = s_quo;
                        n_quo   = s_quo;
                        n_dvs   = r_d;
                        n_state = ST_STRIP;
                    end else begin
                        n_d   = d_inc;
                        n_quo = r_rest;
                        n_dvs = d_inc;
                    end
                end
            end
            ST_STRIP: begin
                // Keep dividing out d until it no longer divides the rest.
                if (s_done) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (s_rem == '0) begin
                        n_rest = s_quo;
                        n_quo  = s_quo;
                        n_dvs  = r_d;
                    end else begin
                        n_quo   = r_acc;
                        n_dvs   = r_d;
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (s_done) begin
                    n_acc   = r_acc - s_quo;
                    n_d     = d_inc;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_quo   = r_rest;
                    n_dvs   = d_inc;
                    n_state = ST_TEST;
                end
            end
            ST_LAST: begin
                // The rest above one is a prime factor of its own.
                if (s_done) begin
                    n_acc   = r_acc - s_quo;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_totient   = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest    <= n_rest;
        r_acc     <= n_acc;
        r_d       <= n_d;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvs     <= n_dvs;
        r_cnt     <= n_cnt;
        r_totient <= n_totient;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_totient   = r_totient;

endmodule
`default_nettype wire
